[sv/abmt_pkg.sv]
// Shared types and constants for the box-by-matrix transform unit.
// Used by abmt_proj and aabb_matrix_transform_unit; depends on nothing.
package abmt_pkg;

   localparam int DEF_COORD_WIDTH    = 32;
   localparam int DEF_COEF_FRAC_BITS = 12;
   localparam int NUM_CORNERS        = 8;
   localparam int NUM_AXES           = 3;
   localparam int NUM_ROWS           = 4;
   localparam int FRAC_BITS          = 16;
   localparam int COEF_WIDTH         = 16;
   localparam int ACC_WIDTH          = 64;
   localparam int CSR_INDEX_WIDTH    = 3;

   // register map of the csr channel
   typedef enum logic [CSR_INDEX_WIDTH-1:0] {
      CSR_ENABLE = 3'd0,
      CSR_ROW0   = 3'd1,
      CSR_ROW1   = 3'd2,
      CSR_ROW2   = 3'd3,
      CSR_ROW3   = 3'd4
   } csr_index_type;

   // per-coordinate status carried from the projection stage to the reduction tree
   typedef struct packed {
      logic fault;
      logic sat;
   } abmt_flags_type;

   // projection unit: magnitude, range check, one stage per quotient bit, clip
   function automatic int proj_latency(input int cw);
      return cw + 4;
   endfunction

endpackage

[sv/abmt_proj.sv]
// Pipelined perspective divide of one corner coordinate: num * 2^16 / w, clipped.
// Restoring division, one quotient bit per stage. Depends on abmt_pkg.
module abmt_proj #(
   parameter int COORD_WIDTH = abmt_pkg::DEF_COORD_WIDTH
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           in_valid,
   input  logic signed [63:0]             num,
   input  logic signed [63:0]             den,
   output logic                           out_valid,
   output logic signed [COORD_WIDTH:0]    corner,
   output abmt_pkg::abmt_flags_type       flags
);
   import abmt_pkg::*;

   localparam int QW  = COORD_WIDTH + 1;
   localparam int RW  = ACC_WIDTH + 1;
   localparam int LAT = proj_latency(COORD_WIDTH);

   // valid pipe
   logic [LAT-1:0] vld_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= {vld_ff[LAT-2:0], in_valid};
      end
   end
   assign out_valid = vld_ff[LAT-1];

   // magnitudes and sign/zero classification
   logic [63:0] m_un_ff, m_ud_ff;
   logic        m_neg_ff, m_zero_ff, m_nzero_ff, m_npos_ff;
   always_ff @(posedge clock) begin
      m_un_ff    <= num[63] ? (64'd0 - unsigned'(num)) : unsigned'(num);
      m_ud_ff    <= den[63] ? (64'd0 - unsigned'(den)) : unsigned'(den);
      m_neg_ff   <= num[63] ^ den[63];
      m_zero_ff  <= (den == '0);
      m_nzero_ff <= (num == '0);
      m_npos_ff  <= !num[63] && (num != '0);
   end

   // division pipe; index 0 holds the initial partial remainder
   logic [RW-1:0] st_r_ff    [0:QW];
   logic [QW-1:0] st_q_ff    [0:QW];
   logic [63:0]   st_un_ff   [0:QW];
   logic [63:0]   st_ud_ff   [0:QW];
   logic          st_big_ff  [0:QW];
   logic          st_neg_ff  [0:QW];
   logic          st_zero_ff [0:QW];
   logic          st_nzero_ff[0:QW];
   logic          st_npos_ff [0:QW];

   // integer part too large for the corner range is flagged up front
   logic [RW-1:0] r0;
   assign r0 = {1'b0, m_un_ff >> (COORD_WIDTH - 15)};
   always_ff @(posedge clock) begin
      st_r_ff[0]     <= r0;
      st_q_ff[0]     <= '0;
      st_un_ff[0]    <= m_un_ff;
      st_ud_ff[0]    <= m_ud_ff;
      st_big_ff[0]   <= (r0 >= {1'b0, m_ud_ff});
      st_neg_ff[0]   <= m_neg_ff;
      st_zero_ff[0]  <= m_zero_ff;
      st_nzero_ff[0] <= m_nzero_ff;
      st_npos_ff[0]  <= m_npos_ff;
   end

   for (genvar k = 0; k < QW; k++) begin : g_step
      localparam int J = QW - 1 - k;
      logic          nbit;
      logic [RW-1:0] rsh, rdif;
      logic          ge;
      if (J >= FRAC_BITS) begin : g_data
         assign nbit = st_un_ff[k][J-FRAC_BITS];
      end else begin : g_zero
         assign nbit = 1'b0;
      end
      assign rsh  = {st_r_ff[k][RW-2:0], nbit};
      assign rdif = rsh - {1'b0, st_ud_ff[k]};
      assign ge   = (rsh >= {1'b0, st_ud_ff[k]});
      always_ff @(posedge clock) begin
         st_r_ff[k+1]     <= ge ? rdif : rsh;
         st_q_ff[k+1]     <= {st_q_ff[k][QW-2:0], ge};
         st_un_ff[k+1]    <= st_un_ff[k];
         st_ud_ff[k+1]    <= st_ud_ff[k];
         st_big_ff[k+1]   <= st_big_ff[k];
         st_neg_ff[k+1]   <= st_neg_ff[k];
         st_zero_ff[k+1]  <= st_zero_ff[k];
         st_nzero_ff[k+1] <= st_nzero_ff[k];
         st_npos_ff[k+1]  <= st_npos_ff[k];
      end
   end

   // sign, clip and zero-w handling
   localparam logic signed [QW-1:0] CMAX = {1'b0, {(QW-1){1'b1}}};
   localparam logic signed [QW-1:0] CMIN = {1'b1, {(QW-1){1'b0}}};
   logic [QW-1:0]        qf;
   logic                 over_neg, over_pos;
   logic signed [QW-1:0] corner_in;
   abmt_flags_type       flags_in;
   assign qf       = st_q_ff[QW];
   assign over_neg = st_big_ff[QW] || (qf[QW-1] && (|qf[QW-2:0]));
   assign over_pos = st_big_ff[QW] || qf[QW-1];

   always_comb begin
      flags_in.fault = 1'b0;
      flags_in.sat   = 1'b0;
      if (st_zero_ff[QW]) begin
         flags_in.fault = 1'b1;
         if (st_nzero_ff[QW]) begin
            corner_in = '0;
         end else begin
            flags_in.sat = 1'b1;
            corner_in    = st_npos_ff[QW] ? CMAX : CMIN;
         end
      end else if (st_neg_ff[QW]) begin
         flags_in.sat = over_neg;
         corner_in    = over_neg ? CMIN : signed'(QW'(0) - qf);
      end else begin
         flags_in.sat = over_pos;
         corner_in    = over_pos ? CMAX : signed'(qf);
      end
   end

   logic signed [QW-1:0] corner_ff;
   abmt_flags_type       flags_ff;
   always_ff @(posedge clock) begin
      corner_ff <= corner_in;
      flags_ff  <= flags_in;
   end
   assign corner = corner_ff;
   assign flags  = flags_ff;

`ifndef ASSERT_OFF
   // a zero w yields only zero or a rail value
   a_fault_value: assert property (@(posedge clock) disable iff (reset)
      out_valid && flags.fault |-> (corner == '0 || corner == CMAX || corner == CMIN))
      else $error("abmt_proj: zero-w result off the rails");
   // a nonzero result from a zero w is a clip
   a_fault_sat: assert property (@(posedge clock) disable iff (reset)
      out_valid && flags.fault && corner != '0 |-> flags.sat)
      else $error("abmt_proj: zero-w rail without saturation");
   // a clipped quotient lands on a rail
   a_sat_rail: assert property (@(posedge clock) disable iff (reset)
      out_valid && flags.sat |-> (corner == CMAX || corner == CMIN))
      else $error("abmt_proj: saturated value off the rails");
`endif

endmodule

[sv/aabb_matrix_transform_unit.sv]
// Top level: bounding box of an axis-aligned box after a 4x4 world transform.
// Instantiates abmt_proj for each corner coordinate; depends on abmt_pkg.
//
// Usage:
//  - Input: a box transaction (center, half-extents, Q16.16) is taken at each
//    rising edge with start high; busy is always low, so one box per cycle.
//  - Output: rsp_valid pulses for one cycle with the bounding box of the eight
//    corners, transformed by the matrix (divide by w) when enabled, else as is.
//    Results come back in order, through the input, corner, multiply and sum
//    stages, the projection divider (one quotient bit per stage), a three-level
//    min/max tree and the output register. Throughput is one box per clock.
//  - csr: writes of the enable bit and the four matrix rows are always
//    accepted (csr_ready high); write only while no box is in flight.
//  - Reset clears the valid pipe and loads transform off with an identity
//    matrix. The receiver cannot stall; every result is shown once.
module aabb_matrix_transform_unit #(
   parameter int COORD_WIDTH    = abmt_pkg::DEF_COORD_WIDTH,
   parameter int COEF_FRAC_BITS = abmt_pkg::DEF_COEF_FRAC_BITS
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   start,
   output logic                                   busy,
   input  logic signed [COORD_WIDTH-1:0]          req_center_x,
   input  logic signed [COORD_WIDTH-1:0]          req_center_y,
   input  logic signed [COORD_WIDTH-1:0]          req_center_z,
   input  logic [COORD_WIDTH-2:0]                 req_half_x,
   input  logic [COORD_WIDTH-2:0]                 req_half_y,
   input  logic [COORD_WIDTH-2:0]                 req_half_z,
   output logic                                   rsp_valid,
   output logic signed [COORD_WIDTH-1:0]          rsp_out_center_x,
   output logic signed [COORD_WIDTH-1:0]          rsp_out_center_y,
   output logic signed [COORD_WIDTH-1:0]          rsp_out_center_z,
   output logic [COORD_WIDTH-2:0]                 rsp_out_half_x,
   output logic [COORD_WIDTH-2:0]                 rsp_out_half_y,
   output logic [COORD_WIDTH-2:0]                 rsp_out_half_z,
   output logic                                   rsp_divide_fault,
   output logic                                   rsp_saturated,
   input  logic                                   csr_valid,
   output logic                                   csr_ready,
   input  logic [abmt_pkg::CSR_INDEX_WIDTH-1:0]   csr_index,
   input  logic [abmt_pkg::ACC_WIDTH-1:0]         csr_data
);
   import abmt_pkg::*;

   localparam int CW  = COORD_WIDTH;
   localparam int PW  = CW + 1;
   localparam int PRW = PW + COEF_WIDTH;

   assign busy      = 1'b0;
   assign csr_ready = 1'b1;

   // configuration registers
   logic                 en_ff;
   logic [ACC_WIDTH-1:0] row_ff [NUM_ROWS];
   always_ff @(posedge clock) begin
      if (reset) begin
         en_ff <= 1'b0;
         for (int r = 0; r < NUM_ROWS; r++) begin
            row_ff[r] <= ACC_WIDTH'(1) << (COEF_FRAC_BITS + COEF_WIDTH * r);
         end
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_ENABLE: en_ff     <= csr_data[0];
            CSR_ROW0:   row_ff[0] <= csr_data;
            CSR_ROW1:   row_ff[1] <= csr_data;
            CSR_ROW2:   row_ff[2] <= csr_data;
            CSR_ROW3:   row_ff[3] <= csr_data;
            default:    ;
         endcase
      end
   end

   // effective coefficients; identity when the transform is off
   logic signed [COEF_WIDTH-1:0] coef [NUM_ROWS][NUM_ROWS];
   always_comb begin
      for (int r = 0; r < NUM_ROWS; r++) begin
         for (int c = 0; c < NUM_ROWS; c++) begin
            if (en_ff) begin
               coef[r][c] = signed'(row_ff[r][COEF_WIDTH*c +: COEF_WIDTH]);
            end else begin
               coef[r][c] = (r == c) ? signed'(COEF_WIDTH'(1) << COEF_FRAC_BITS) : '0;
            end
         end
      end
   end

   // front valid pipe: input, corner, product, sum stages
   logic [3:0] fv_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         fv_ff <= '0;
      end else begin
         fv_ff <= {fv_ff[2:0], start && !busy};
      end
   end

   // input register
   logic signed [CW-1:0] c1_ff [NUM_AXES];
   logic [CW-2:0]        h1_ff [NUM_AXES];
   always_ff @(posedge clock) begin
      c1_ff[0] <= req_center_x;
      c1_ff[1] <= req_center_y;
      c1_ff[2] <= req_center_z;
      h1_ff[0] <= req_half_x;
      h1_ff[1] <= req_half_y;
      h1_ff[2] <= req_half_z;
   end

   // corners: bit a of the corner number picks the minus side on axis a
   logic signed [PW-1:0] p2_ff [NUM_CORNERS][NUM_AXES];
   always_ff @(posedge clock) begin
      for (int k = 0; k < NUM_CORNERS; k++) begin
         for (int a = 0; a < NUM_AXES; a++) begin
            p2_ff[k][a] <= ((k >> a) & 1) != 0
                         ? PW'(c1_ff[a]) - signed'(PW'(h1_ff[a]))
                         : PW'(c1_ff[a]) + signed'(PW'(h1_ff[a]));
         end
      end
   end

   // products x*m0c, y*m1c, z*m2c
   logic signed [PRW-1:0] pr3_ff [NUM_CORNERS][NUM_ROWS][NUM_AXES];
   always_ff @(posedge clock) begin
      for (int k = 0; k < NUM_CORNERS; k++) begin
         for (int c = 0; c < NUM_ROWS; c++) begin
            for (int a = 0; a < NUM_AXES; a++) begin
               pr3_ff[k][c][a] <= PRW'(p2_ff[k][a]) * PRW'(coef[a][c]);
            end
         end
      end
   end

   // dot products, wrapping at 64 bits, with the translation term
   logic signed [ACC_WIDTH-1:0] acc4_ff [NUM_CORNERS][NUM_ROWS];
   always_ff @(posedge clock) begin
      for (int k = 0; k < NUM_CORNERS; k++) begin
         for (int c = 0; c < NUM_ROWS; c++) begin
            acc4_ff[k][c] <= ACC_WIDTH'(pr3_ff[k][c][0]) + ACC_WIDTH'(pr3_ff[k][c][1])
                           + ACC_WIDTH'(pr3_ff[k][c][2])
                           + (ACC_WIDTH'(coef[3][c]) <<< FRAC_BITS);
         end
      end
   end

   // projection of every corner coordinate
   logic signed [PW-1:0] pj      [NUM_CORNERS][NUM_AXES];
   abmt_flags_type       pj_flag [NUM_CORNERS][NUM_AXES];
   logic [NUM_CORNERS*NUM_AXES-1:0] pj_vld;
   for (genvar k = 0; k < NUM_CORNERS; k++) begin : g_corner
      for (genvar a = 0; a < NUM_AXES; a++) begin : g_axis
         abmt_proj #(.COORD_WIDTH(COORD_WIDTH)) u_proj (
            .clock     (clock),
            .reset     (reset),
            .in_valid  (fv_ff[3]),
            .num       (acc4_ff[k][a]),
            .den       (acc4_ff[k][3]),
            .out_valid (pj_vld[k*NUM_AXES + a]),
            .corner    (pj[k][a]),
            .flags     (pj_flag[k][a])
         );
      end
   end

   // min/max tree, level 1: pairs of corners
   logic signed [PW-1:0] lo1_ff [4][NUM_AXES], hi1_ff [4][NUM_AXES];
   abmt_flags_type       f1_ff  [4];
   always_ff @(posedge clock) begin
      for (int i = 0; i < 4; i++) begin
         for (int a = 0; a < NUM_AXES; a++) begin
            lo1_ff[i][a] <= (pj[2*i][a] < pj[2*i+1][a]) ? pj[2*i][a] : pj[2*i+1][a];
            hi1_ff[i][a] <= (pj[2*i][a] > pj[2*i+1][a]) ? pj[2*i][a] : pj[2*i+1][a];
         end
         f1_ff[i].fault <= pj_flag[2*i][0].fault | pj_flag[2*i][1].fault
                         | pj_flag[2*i][2].fault | pj_flag[2*i+1][0].fault
                         | pj_flag[2*i+1][1].fault | pj_flag[2*i+1][2].fault;
         f1_ff[i].sat   <= pj_flag[2*i][0].sat | pj_flag[2*i][1].sat
                         | pj_flag[2*i][2].sat | pj_flag[2*i+1][0].sat
                         | pj_flag[2*i+1][1].sat | pj_flag[2*i+1][2].sat;
      end
   end

   // level 2
   logic signed [PW-1:0] lo2_ff [2][NUM_AXES], hi2_ff [2][NUM_AXES];
   abmt_flags_type       f2_ff  [2];
   always_ff @(posedge clock) begin
      for (int i = 0; i < 2; i++) begin
         for (int a = 0; a < NUM_AXES; a++) begin
            lo2_ff[i][a] <= (lo1_ff[2*i][a] < lo1_ff[2*i+1][a])
                          ? lo1_ff[2*i][a] : lo1_ff[2*i+1][a];
            hi2_ff[i][a] <= (hi1_ff[2*i][a] > hi1_ff[2*i+1][a])
                          ? hi1_ff[2*i][a] : hi1_ff[2*i+1][a];
         end
         f2_ff[i] <= f1_ff[2*i] | f1_ff[2*i+1];
      end
   end

   // level 3
   logic signed [PW-1:0] lo3_ff [NUM_AXES], hi3_ff [NUM_AXES];
   abmt_flags_type       f3_ff;
   always_ff @(posedge clock) begin
      for (int a = 0; a < NUM_AXES; a++) begin
         lo3_ff[a] <= (lo2_ff[0][a] < lo2_ff[1][a]) ? lo2_ff[0][a] : lo2_ff[1][a];
         hi3_ff[a] <= (hi2_ff[0][a] > hi2_ff[1][a]) ? hi2_ff[0][a] : hi2_ff[1][a];
      end
      f3_ff <= f2_ff[0] | f2_ff[1];
   end

   // back valid pipe: three tree levels and the output register
   logic [3:0] bv_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         bv_ff <= '0;
      end else begin
         bv_ff <= {bv_ff[2:0], &pj_vld};
      end
   end

   // center and half-extent with clipping
   logic signed [CW-1:0] ctr_out [NUM_AXES];
   logic [CW-2:0]        hw_out  [NUM_AXES];
   logic                 clip_any;
   always_comb begin
      logic signed [PW:0] sum, dif;
      logic [PW-1:0]      ctr, hw;
      logic               ovc, ovh;
      clip_any = 1'b0;
      for (int a = 0; a < NUM_AXES; a++) begin
         sum = (PW+1)'(lo3_ff[a]) + (PW+1)'(hi3_ff[a]);
         dif = (PW+1)'(hi3_ff[a]) - (PW+1)'(lo3_ff[a]);
         ctr = sum[PW:1];
         hw  = dif[PW:1];
         ovc = ctr[CW] != ctr[CW-1];
         ovh = hw[CW] | hw[CW-1];
         ctr_out[a] = ovc ? signed'({ctr[CW], {(CW-1){~ctr[CW]}}}) : signed'(ctr[CW-1:0]);
         hw_out[a]  = ovh ? {(CW-1){1'b1}} : hw[CW-2:0];
         clip_any   = clip_any | ovc | ovh;
      end
   end

   // output register
   logic signed [CW-1:0] oc_ff [NUM_AXES];
   logic [CW-2:0]        oh_ff [NUM_AXES];
   logic                 ofault_ff, osat_ff;
   always_ff @(posedge clock) begin
      for (int a = 0; a < NUM_AXES; a++) begin
         oc_ff[a] <= ctr_out[a];
         oh_ff[a] <= hw_out[a];
      end
      ofault_ff <= f3_ff.fault;
      osat_ff   <= f3_ff.sat | clip_any;
   end

   assign rsp_valid        = bv_ff[3];
   assign rsp_out_center_x = oc_ff[0];
   assign rsp_out_center_y = oc_ff[1];
   assign rsp_out_center_z = oc_ff[2];
   assign rsp_out_half_x   = oh_ff[0];
   assign rsp_out_half_y   = oh_ff[1];
   assign rsp_out_half_z   = oh_ff[2];
   assign rsp_divide_fault = ofault_ff;
   assign rsp_saturated    = osat_ff;

`ifndef ASSERT_OFF
   // reduction tree keeps min at or below max on every axis
   a_tree_order: assert property (@(posedge clock) disable iff (reset)
      bv_ff[2] |-> (lo3_ff[0] <= hi3_ff[0] && lo3_ff[1] <= hi3_ff[1]
                    && lo3_ff[2] <= hi3_ff[2]))
      else $error("aabb_matrix_transform_unit: min above max");
   // enable write lands in the register
   a_csr_enable: assert property (@(posedge clock) disable iff (reset)
      csr_valid && csr_ready && csr_index == CSR_ENABLE |=> en_ff == $past(csr_data[0]))
      else $error("aabb_matrix_transform_unit: enable write lost");
   // row 0 write lands in the register
   a_csr_row0: assert property (@(posedge clock) disable iff (reset)
      csr_valid && csr_ready && csr_index == CSR_ROW0 |=> row_ff[0] == $past(csr_data))
      else $error("aabb_matrix_transform_unit: row write lost");
`endif

endmodule
